FILE: rtl/isotropic_binary_collision_defines.svh
// Assertion macros for the checker file ibc_checker.sv.
`ifndef ISOTROPIC_BINARY_COLLISION_DEFINES_SVH
`define ISOTROPIC_BINARY_COLLISION_DEFINES_SVH

// Same-cycle implication.
`define IBC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define IBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/ibc_pkg.sv
`default_nettype none
package ibc_pkg;

  typedef logic signed [31:0] vel_t;

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quad_e;

  localparam logic [23:0] MASS_RESET = 24'd256;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam logic signed [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    vel_t fx;
    vel_t fy;
    vel_t fz;
    vel_t sx;
    vel_t sy;
    vel_t sz;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/ibc_out_skid.sv
`default_nettype none
module ibc_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ibc_pkg::result_t push_data_i,
  output logic             can_push_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ibc_pkg::result_t out_data_o
);

  ibc_pkg::result_t mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign can_push_o  = (cnt_q != 2'd2) | out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_q ^ push_i;
      rd_q  <= rd_q ^ pop;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/isotropic_binary_collision.sv
// Isotropic elastic binary collision, one particle pair per cycle unless the output stalls.
// Input channel (in_valid_i / in_ready_o) carries both velocities, both
// species indices and the two random fractions; output channel
// (out_valid_o / out_ready_i) carries both post-collision velocities.
// A transfer happens when valid and ready are both high at a clock edge.
// The configuration port writes species masses whenever cfg_we_i is high;
// write only while the pipeline is empty. Indexes above 3 are ignored.
// An input pair passes the input registers, the 33 stages of the root
// extraction (CORDIC runs alongside), the product registers and the 33
// stages of the rounding divider by the mass sum, then the output buffer.
// Throughput: one pair per cycle while the pipeline is not held.
// The output side has a two-entry buffer: while one result waits the
// pipeline keeps moving; the whole pipeline holds only when the buffer is
// full and out_ready_i is low, and in_ready_o then drops. Nothing is lost
// or repeated across a stall.
// Reset (rst_ni low) empties the pipeline and sets every mass to 256.
`default_nettype none
module isotropic_binary_collision #(
  parameter int unsigned NUM_SPECIES  = 4,
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  first_vel_x_i,
  input  logic signed [31:0]  first_vel_y_i,
  input  logic signed [31:0]  first_vel_z_i,
  input  logic signed [31:0]  second_vel_x_i,
  input  logic signed [31:0]  second_vel_y_i,
  input  logic signed [31:0]  second_vel_z_i,
  input  logic [1:0]          first_species_i,
  input  logic [1:0]          second_species_i,
  input  logic [23:0]         rand_polar_i,
  input  logic [23:0]         rand_azimuth_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  new_first_vel_x_o,
  output logic signed [31:0]  new_first_vel_y_o,
  output logic signed [31:0]  new_first_vel_z_o,
  output logic signed [31:0]  new_second_vel_x_o,
  output logic signed [31:0]  new_second_vel_y_o,
  output logic signed [31:0]  new_second_vel_z_o
);

  localparam int unsigned SqSteps  = 33;
  localparam int unsigned DivSteps = 33;

  typedef struct packed {
    ibc_pkg::vel_t [2:0] a;
    ibc_pkg::vel_t [2:0] b;
    logic [23:0]         mp;
    logic [23:0]         mq;
    logic [24:0]         msum;
  } car_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [32:0] root;
  } sqs_t;

  typedef struct packed {
    car_t               car;
    logic [65:0]        rad_c;
    logic [48:0]        rad_s;
    sqs_t               rc;
    sqs_t               rs;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [25:0] c;
    logic [1:0]         quad;
  } sq_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [32:0] mag;
    logic [24:0] rem;
    logic [32:0] q;
  } dl_t;

  typedef struct packed {
    dl_t [5:0]   ln;
    logic [24:0] msum;
  } dv_t;

  function automatic sqs_t root_step(input sqs_t s, input logic [1:0] pair);
    logic [36:0] r4;
    logic [36:0] trial;
    sqs_t        o;
    r4    = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (r4 >= trial) begin
      o.rem  = 35'(r4 - trial);
      o.root = {s.root[31:0], 1'b1};
    end else begin
      o.rem  = 35'(r4);
      o.root = {s.root[31:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [31:0] abs_diff(input logic signed [31:0] p,
                                           input logic signed [31:0] q);
    logic signed [32:0] d;
    d = 33'(p) - 33'(q);
    return d[32] ? 32'(-d) : 32'(d);
  endfunction

  function automatic ibc_pkg::vel_t saturate(input dl_t l);
    ibc_pkg::vel_t r;
    if (l.neg) begin
      r = (l.ovf || l.q > 33'h080000000) ? 32'sh80000000 : 32'(33'd0 - l.q);
    end else begin
      r = (l.ovf || l.q > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(l.q[31:0]);
    end
    return r;
  endfunction

  logic en;

  // species masses
  logic [23:0] mass_q [NUM_SPECIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SPECIES; k++) mass_q[k] <= ibc_pkg::MASS_RESET;
    end else if (cfg_we_i) begin
      for (int k = 0; k < NUM_SPECIES; k++) begin
        if (cfg_index_i == 3'(k)) mass_q[k] <= cfg_wdata_i;
      end
    end
  end

  logic [1:0]  sel_p, sel_q;
  logic [23:0] mp_raw, mq_raw, mp_in, mq_in;

  always_comb begin
    sel_p  = (32'(first_species_i) >= NUM_SPECIES) ? 2'(NUM_SPECIES - 1) : first_species_i;
    sel_q  = (32'(second_species_i) >= NUM_SPECIES) ? 2'(NUM_SPECIES - 1) : second_species_i;
    mp_raw = '0;
    mq_raw = '0;
    for (int k = 0; k < NUM_SPECIES; k++) begin
      if (sel_p == 2'(k)) mp_raw = mass_q[k];
      if (sel_q == 2'(k)) mq_raw = mass_q[k];
    end
  end

  assign mp_in = (mp_raw == '0) ? 24'd1 : mp_raw;
  assign mq_in = (mq_raw == '0) ? 24'd1 : mq_raw;

  // stage 0: register inputs, differences, cos theta, azimuth angle
  car_t               car_in;
  logic [2:0][31:0]   ad_in;
  logic signed [25:0] c_in;
  logic [52:0]        zp_in;

  always_comb begin
    car_in.a    = {first_vel_z_i, first_vel_y_i, first_vel_x_i};
    car_in.b    = {second_vel_z_i, second_vel_y_i, second_vel_x_i};
    car_in.mp   = mp_in;
    car_in.mq   = mq_in;
    car_in.msum = 25'(mp_in) + 25'(mq_in);
    ad_in[0]    = abs_diff(first_vel_x_i, second_vel_x_i);
    ad_in[1]    = abs_diff(first_vel_y_i, second_vel_y_i);
    ad_in[2]    = abs_diff(first_vel_z_i, second_vel_z_i);
    c_in        = $signed({1'b0, rand_polar_i, 1'b0}) - 26'sd16777216;
    zp_in       = 53'(rand_azimuth_i[21:0]) * 53'(ibc_pkg::HALF_PI_Q30);
  end

  car_t               car0_q, car1_q, car2_q;
  logic [2:0][31:0]   ad0_q;
  logic signed [25:0] c0_q, c1_q, c2_q;
  logic signed [31:0] z0_q, z1_q, z2_q;
  logic [1:0]         quad0_q, quad1_q, quad2_q;
  logic               v0_q, v1_q, v2_q;
  logic [2:0][63:0]   sq1_q;
  logic [48:0]        sv1_q, sv2_q;
  logic [65:0]        sum2_q;
  logic signed [51:0] csq;

  assign csq = c0_q * c0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      car0_q  <= car_in;
      ad0_q   <= ad_in;
      c0_q    <= c_in;
      z0_q    <= $signed({1'b0, zp_in[52:22]});
      quad0_q <= rand_azimuth_i[23:22];
      car1_q  <= car0_q;
      for (int i = 0; i < 3; i++) sq1_q[i] <= 64'(ad0_q[i]) * 64'(ad0_q[i]);
      sv1_q   <= 49'h1000000000000 - csq[48:0];
      c1_q    <= c0_q;
      z1_q    <= z0_q;
      quad1_q <= quad0_q;
      car2_q  <= car1_q;
      sum2_q  <= 66'(sq1_q[0]) + 66'(sq1_q[1]) + 66'(sq1_q[2]);
      sv2_q   <= sv1_q;
      c2_q    <= c1_q;
      z2_q    <= z1_q;
      quad2_q <= quad1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // root extraction, one step per stage; CORDIC, one step in each of the first CORDIC_STEPS stages
  sq_t  sq_init;
  sq_t  sqp_q [SqSteps];
  logic sqv_q [SqSteps];

  always_comb begin
    sq_init       = '0;
    sq_init.car   = car2_q;
    sq_init.rad_c = sum2_q;
    sq_init.rad_s = sv2_q;
    sq_init.x     = ibc_pkg::CORDIC_GAIN_Q30;
    sq_init.z     = z2_q;
    sq_init.c     = c2_q;
    sq_init.quad  = quad2_q;
  end

  for (genvar j = 0; j < SqSteps; j++) begin : g_sq
    sq_t                prev, nxt;
    logic               prev_v;
    logic signed [31:0] xr, yr, zr;

    if (j == 0) begin : g_first
      assign prev   = sq_init;
      assign prev_v = v2_q;
    end else begin : g_next
      assign prev   = sqp_q[j-1];
      assign prev_v = sqv_q[j-1];
    end

    if (j < CORDIC_STEPS) begin : g_rot
      logic signed [31:0] xs, ys;
      assign xs = prev.x >>> j;
      assign ys = prev.y >>> j;
      always_comb begin
        if (!prev.z[31]) begin
          xr = prev.x - ys;
          yr = prev.y + xs;
          zr = prev.z - ibc_pkg::ATAN_Q30[j];
        end else begin
          xr = prev.x + ys;
          yr = prev.y - xs;
          zr = prev.z + ibc_pkg::ATAN_Q30[j];
        end
      end
    end else begin : g_hold
      assign xr = prev.x;
      assign yr = prev.y;
      assign zr = prev.z;
    end

    always_comb begin
      nxt    = prev;
      nxt.rc = root_step(prev.rc, 2'(prev.rad_c >> (64 - 2 * j)));
      nxt.rs = root_step(prev.rs, 2'(66'(prev.rad_s) >> (64 - 2 * j)));
      nxt.x  = xr;
      nxt.y  = yr;
      nxt.z  = zr;
    end

    always_ff @(posedge clk_i) begin
      if (en) sqp_q[j] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[j] <= 1'b0;
      end else if (en) begin
        sqv_q[j] <= prev_v;
      end
    end
  end

  // M1: relative x and transverse magnitude, quadrant fold
  sq_t                sl;
  logic signed [59:0] pc, pcr, ps, psr;
  logic signed [31:0] cphi, sphi;

  assign sl  = sqp_q[SqSteps-1];
  assign pc  = $signed({1'b0, sl.rc.root}) * sl.c;
  assign ps  = $signed({1'b0, sl.rc.root}) * $signed({1'b0, sl.rs.root[24:0]});
  assign pcr = pc + 60'sd8388608;
  assign psr = ps + 60'sd8388608;

  always_comb begin
    case (ibc_pkg::quad_e'(sl.quad))
      ibc_pkg::QUAD_FIRST: begin
        cphi = sl.x;
        sphi = sl.y;
      end
      ibc_pkg::QUAD_SECOND: begin
        cphi = -sl.y;
        sphi = sl.x;
      end
      ibc_pkg::QUAD_THIRD: begin
        cphi = -sl.x;
        sphi = -sl.y;
      end
      default: begin
        cphi = sl.y;
        sphi = -sl.x;
      end
    endcase
  end

  car_t               car_m1_q, car_m2_q;
  logic signed [34:0] rx_m1_q, t_m1_q;
  logic signed [31:0] cphi_m1_q, sphi_m1_q;
  logic [2:0][34:0]   r_m2_q;
  logic signed [66:0] py, pz, pyr, pzr;
  logic               v_m1_q, v_m2_q, v_m3_q, v_m4_q, v_m5_q;

  assign py  = t_m1_q * cphi_m1_q;
  assign pz  = t_m1_q * sphi_m1_q;
  assign pyr = py + 67'sd536870912;
  assign pzr = pz + 67'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en) begin
      car_m1_q  <= sl.car;
      rx_m1_q   <= pcr[58:24];
      t_m1_q    <= psr[58:24];
      cphi_m1_q <= cphi;
      sphi_m1_q <= sphi;
      car_m2_q  <= car_m1_q;
      r_m2_q    <= {pzr[64:30], pyr[64:30], rx_m1_q};
    end
  end

  // M3: mass products
  logic signed [24:0] mp_s, mq_s;
  logic signed [56:0] pa_c [3];
  logic signed [56:0] qb_c [3];
  logic signed [59:0] qr_c [3];
  logic signed [59:0] pr_c [3];

  assign mp_s = $signed({1'b0, car_m2_q.mp});
  assign mq_s = $signed({1'b0, car_m2_q.mq});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_c[i] = mp_s * $signed(car_m2_q.a[i]);
      qb_c[i] = mq_s * $signed(car_m2_q.b[i]);
      qr_c[i] = mq_s * $signed(r_m2_q[i]);
      pr_c[i] = mp_s * $signed(r_m2_q[i]);
    end
  end

  logic [2:0][56:0] pa_m3_q, qb_m3_q;
  logic [2:0][59:0] qr_m3_q, pr_m3_q;
  logic [24:0]      msum_m3_q, msum_m4_q;
  logic [5:0][59:0] n_m4_q;
  logic signed [59:0] n1_c [3];
  logic signed [59:0] n2_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_c[i] = $signed(pa_m3_q[i]) + $signed(qb_m3_q[i]) + $signed(qr_m3_q[i]);
      n2_c[i] = $signed(pa_m3_q[i]) + $signed(qb_m3_q[i]) - $signed(pr_m3_q[i]);
    end
  end

  // M5: sign, rounding offset, overflow test, divider seed
  dv_t                dv_init;
  logic signed [59:0] nv;
  logic [59:0]        absn, mag;

  always_comb begin
    dv_init      = '0;
    dv_init.msum = msum_m4_q;
    nv           = '0;
    absn         = '0;
    mag          = '0;
    for (int i = 0; i < 6; i++) begin
      nv                 = $signed(n_m4_q[i]);
      absn               = nv[59] ? 60'(-nv) : 60'(nv);
      mag                = absn + 60'(msum_m4_q[24:1]);
      dv_init.ln[i].neg  = nv[59];
      dv_init.ln[i].ovf  = (mag[59:33] >= 27'(msum_m4_q));
      dv_init.ln[i].mag  = mag[32:0];
      dv_init.ln[i].rem  = mag[57:33];
    end
  end

  dv_t dv_m5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_m3_q[i]      <= pa_c[i];
        qb_m3_q[i]      <= qb_c[i];
        qr_m3_q[i]      <= qr_c[i];
        pr_m3_q[i]      <= pr_c[i];
        n_m4_q[i]       <= n1_c[i];
        n_m4_q[3 + i]   <= n2_c[i];
      end
      msum_m3_q <= car_m2_q.msum;
      msum_m4_q <= msum_m3_q;
      dv_m5_q   <= dv_init;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_m1_q <= 1'b0;
      v_m2_q <= 1'b0;
      v_m3_q <= 1'b0;
      v_m4_q <= 1'b0;
      v_m5_q <= 1'b0;
    end else if (en) begin
      v_m1_q <= sqv_q[SqSteps-1];
      v_m2_q <= v_m1_q;
      v_m3_q <= v_m2_q;
      v_m4_q <= v_m3_q;
      v_m5_q <= v_m4_q;
    end
  end

  // restoring divider, one quotient bit per stage
  dv_t  dvp_q [DivSteps];
  logic dvv_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    dv_t  prev, nxt;
    logic prev_v;

    if (k == 0) begin : g_first
      assign prev   = dv_m5_q;
      assign prev_v = v_m5_q;
    end else begin : g_next
      assign prev   = dvp_q[k-1];
      assign prev_v = dvv_q[k-1];
    end

    always_comb begin
      logic [25:0] r2;
      nxt = prev;
      r2  = '0;
      for (int i = 0; i < 6; i++) begin
        r2 = {prev.ln[i].rem, prev.ln[i].mag[DivSteps-1-k]};
        if (r2 >= {1'b0, prev.msum}) begin
          nxt.ln[i].rem = 25'(r2 - {1'b0, prev.msum});
          nxt.ln[i].q   = {prev.ln[i].q[31:0], 1'b1};
        end else begin
          nxt.ln[i].rem = r2[24:0];
          nxt.ln[i].q   = {prev.ln[i].q[31:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) dvp_q[k] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k] <= 1'b0;
      end else if (en) begin
        dvv_q[k] <= prev_v;
      end
    end
  end

  // saturation and output buffer
  dv_t              dl;
  ibc_pkg::result_t res;
  ibc_pkg::result_t out_data;
  logic             can_push;

  assign dl     = dvp_q[DivSteps-1];
  assign res.fx = saturate(dl.ln[0]);
  assign res.fy = saturate(dl.ln[1]);
  assign res.fz = saturate(dl.ln[2]);
  assign res.sx = saturate(dl.ln[3]);
  assign res.sy = saturate(dl.ln[4]);
  assign res.sz = saturate(dl.ln[5]);

  assign en         = can_push;
  assign in_ready_o = en;

  ibc_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (en & dvv_q[DivSteps-1]),
    .push_data_i (res),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign new_first_vel_x_o  = out_data.fx;
  assign new_first_vel_y_o  = out_data.fy;
  assign new_first_vel_z_o  = out_data.fz;
  assign new_second_vel_x_o = out_data.sx;
  assign new_second_vel_y_o = out_data.sy;
  assign new_second_vel_z_o = out_data.sz;

endmodule
`default_nettype wire

FILE: rtl/ibc_checker.sv
`default_nettype none
`include "isotropic_binary_collision_defines.svh"
module ibc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [31:0] new_first_vel_x_o,
  input wire logic signed [31:0] new_first_vel_y_o,
  input wire logic signed [31:0] new_first_vel_z_o,
  input wire logic signed [31:0] new_second_vel_x_o,
  input wire logic signed [31:0] new_second_vel_y_o,
  input wire logic signed [31:0] new_second_vel_z_o
);

  `IBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `IBC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(new_first_vel_x_o) && $stable(new_first_vel_y_o) && $stable(new_first_vel_z_o) && $stable(new_second_vel_x_o) && $stable(new_second_vel_y_o) && $stable(new_second_vel_z_o))
  `IBC_ASSERT_IMPLY(a_ready_follows_sink, clk_i, rst_ni, out_ready_i, in_ready_o)
  `IBC_ASSERT_IMPLY(a_stall_only_full, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind isotropic_binary_collision ibc_checker u_ibc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .new_first_vel_x_o  (new_first_vel_x_o),
  .new_first_vel_y_o  (new_first_vel_y_o),
  .new_first_vel_z_o  (new_first_vel_z_o),
  .new_second_vel_x_o (new_second_vel_x_o),
  .new_second_vel_y_o (new_second_vel_y_o),
  .new_second_vel_z_o (new_second_vel_z_o)
);
`default_nettype wire

FILE: sim/ibc_collision_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module ibc_collision_checker #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] first_vel_x_i,
  input  logic signed [31:0] first_vel_y_i,
  input  logic signed [31:0] first_vel_z_i,
  input  logic signed [31:0] second_vel_x_i,
  input  logic signed [31:0] second_vel_y_i,
  input  logic signed [31:0] second_vel_z_i,
  input  logic [1:0]         first_species_i,
  input  logic [1:0]         second_species_i,
  input  logic [23:0]        rand_polar_i,
  input  logic [23:0]        rand_azimuth_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] new_first_vel_x_i,
  input  logic signed [31:0] new_first_vel_y_i,
  input  logic signed [31:0] new_first_vel_z_i,
  input  logic signed [31:0] new_second_vel_x_i,
  input  logic signed [31:0] new_second_vel_y_i,
  input  logic signed [31:0] new_second_vel_z_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [23:0]      mass_q [4];
  ibc_pkg::result_t post_vel_q [$];

  function automatic logic [67:0] root66(input logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] root;
    logic [67:0] trial;
    rem  = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = {rem[65:0], v[2*i +: 2]};
      trial = {root[65:0], 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[66:0], 1'b1};
      end else begin
        root = {root[66:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic longint rshift_round(input longint v, input int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic ibc_pkg::vel_t div_nearest(input longint n, input logic [63:0] d);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    q = (mag + d / 2) / d;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    if (n < 0) return ibc_pkg::vel_t'(-longint'(q));
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return ibc_pkg::vel_t'(q);
  endfunction

  function automatic longint mass_lookup(input logic [1:0] idx);
    return (mass_q[idx] == 0) ? 64'sd1 : longint'({40'd0, mass_q[idx]});
  endfunction

  function automatic ibc_pkg::result_t collide(input ibc_pkg::vel_t a[3],
                                               input ibc_pkg::vel_t b[3],
                                               input logic [1:0] sp, input logic [1:0] sq,
                                               input logic [23:0] up, input logic [23:0] az);
    logic [65:0]      sum;
    longint           d, cr, c, s, x, y, z, xs, ys, cphi, sphi, t, mp, mq, base;
    longint           r[3];
    ibc_pkg::vel_t    n1[3];
    ibc_pkg::vel_t    n2[3];
    ibc_pkg::result_t res;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = longint'(a[i]) - longint'(b[i]);
      if (d < 0) d = -d;
      sum = sum + {2'b00, 64'(d) * 64'(d)};
    end
    cr = longint'(root66(sum));
    mp = mass_lookup(sp);
    mq = mass_lookup(sq);
    c = longint'({40'd0, up}) * 2 - (longint'(1) <<< 24);
    s = longint'(root66({2'b00, 64'((longint'(1) <<< 48) - c * c)}));
    z = longint'((64'(az[21:0]) * 64'(ibc_pkg::HALF_PI_Q30)) >> 22);
    x = longint'(ibc_pkg::CORDIC_GAIN_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ibc_pkg::ATAN_Q30[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ibc_pkg::ATAN_Q30[i]);
      end
    end
    case (ibc_pkg::quad_e'(az[23:22]))
      ibc_pkg::QUAD_FIRST:  begin cphi = x;  sphi = y;  end
      ibc_pkg::QUAD_SECOND: begin cphi = -y; sphi = x;  end
      ibc_pkg::QUAD_THIRD:  begin cphi = -x; sphi = -y; end
      default:              begin cphi = y;  sphi = -x; end
    endcase
    r[0] = rshift_round(cr * c, 24);
    t    = rshift_round(cr * s, 24);
    r[1] = rshift_round(t * cphi, 30);
    r[2] = rshift_round(t * sphi, 30);
    for (int i = 0; i < 3; i++) begin
      base  = mp * longint'(a[i]) + mq * longint'(b[i]);
      n1[i] = div_nearest(base + mq * r[i], 64'(mp + mq));
      n2[i] = div_nearest(base - mp * r[i], 64'(mp + mq));
    end
    res = '{n1[0], n1[1], n1[2], n2[0], n2[1], n2[2]};
    return res;
  endfunction

  task automatic check_field(input string name, input ibc_pkg::vel_t want,
                             input ibc_pkg::vel_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ibc_pkg::vel_t    a[3];
    ibc_pkg::vel_t    b[3];
    ibc_pkg::result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) mass_q[i] <= ibc_pkg::MASS_RESET;
      post_vel_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (post_vel_q.size() == 0) begin
          $display("%0t: unexpected output transfer, expected none, actual fx=%0d",
                   $time, new_first_vel_x_i);
          fail_count_o++;
        end else begin
          want = post_vel_q.pop_front();
          check_field("new_first_vel_x", want.fx, new_first_vel_x_i);
          check_field("new_first_vel_y", want.fy, new_first_vel_y_i);
          check_field("new_first_vel_z", want.fz, new_first_vel_z_i);
          check_field("new_second_vel_x", want.sx, new_second_vel_x_i);
          check_field("new_second_vel_y", want.sy, new_second_vel_y_i);
          check_field("new_second_vel_z", want.sz, new_second_vel_z_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        a = '{first_vel_x_i, first_vel_y_i, first_vel_z_i};
        b = '{second_vel_x_i, second_vel_y_i, second_vel_z_i};
        post_vel_q.push_back(collide(a, b, first_species_i, second_species_i,
                                     rand_polar_i, rand_azimuth_i));
      end
      if (cfg_we_i && cfg_index_i < 4) mass_q[cfg_index_i[1:0]] <= cfg_wdata_i;
      pending_o <= post_vel_q.size();
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb_isotropic_binary_collision.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_isotropic_binary_collision;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int ITEMS_PER_PHASE = 325;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [2:0]    cfg_index_i = '0;
  logic [23:0]   cfg_wdata_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  ibc_pkg::vel_t first_vel_x_i = '0, first_vel_y_i = '0, first_vel_z_i = '0;
  ibc_pkg::vel_t second_vel_x_i = '0, second_vel_y_i = '0, second_vel_z_i = '0;
  logic [1:0]    first_species_i = '0, second_species_i = '0;
  logic [23:0]   rand_polar_i = '0, rand_azimuth_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  ibc_pkg::vel_t new_first_vel_x_o, new_first_vel_y_o, new_first_vel_z_o;
  ibc_pkg::vel_t new_second_vel_x_o, new_second_vel_y_o, new_second_vel_z_o;
  int            fail_count;
  int            pending;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  isotropic_binary_collision DUT (.*);

  ibc_collision_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .first_vel_x_i, .first_vel_y_i, .first_vel_z_i,
    .second_vel_x_i, .second_vel_y_i, .second_vel_z_i,
    .first_species_i, .second_species_i, .rand_polar_i, .rand_azimuth_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .new_first_vel_x_i(new_first_vel_x_o), .new_first_vel_y_i(new_first_vel_y_o),
    .new_first_vel_z_i(new_first_vel_z_o), .new_second_vel_x_i(new_second_vel_x_o),
    .new_second_vel_y_i(new_second_vel_y_o), .new_second_vel_z_i(new_second_vel_z_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_mass(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0 || (out_valid_o === 1'b1)) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_pair(input ibc_pkg::vel_t fx, input ibc_pkg::vel_t fy,
                           input ibc_pkg::vel_t fz, input ibc_pkg::vel_t sx,
                           input ibc_pkg::vel_t sy, input ibc_pkg::vel_t sz,
                           input logic [1:0] sp, input logic [1:0] sq,
                           input logic [23:0] up, input logic [23:0] az);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    first_vel_x_i    <= fx;
    first_vel_y_i    <= fy;
    first_vel_z_i    <= fz;
    second_vel_x_i   <= sx;
    second_vel_y_i   <= sy;
    second_vel_z_i   <= sz;
    first_species_i  <= sp;
    second_species_i <= sq;
    rand_polar_i     <= up;
    rand_azimuth_i   <= az;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic ibc_pkg::vel_t rand_vel();
    case ($urandom_range(0, 3))
      0: return ibc_pkg::vel_t'($urandom);
      1: return ibc_pkg::vel_t'($urandom_range(0, 2097151)) - 32'sd1048576;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return ibc_pkg::vel_t'($urandom_range(0, 268435455)) - 32'sd134217728;
    endcase
  endfunction

  task automatic send_random();
    send_pair(rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel(),
              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
              24'($urandom), 24'($urandom));
  endtask

  localparam ibc_pkg::vel_t VMAX = 32'sh7FFF_FFFF;
  localparam ibc_pkg::vel_t VMIN = 32'sh8000_0000;

  task automatic send_directed();
    send_pair(0, 0, 0, 0, 0, 0, 2'd0, 2'd0, 24'h000000, 24'h000000);
    send_pair(4096, -4096, 8192, 4096, -4096, 8192, 2'd1, 2'd2, 24'h800000, 24'h400000);
    send_pair(VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, 2'd0, 2'd1, 24'hFFFFFF, 24'hFFFFFF);
    send_pair(VMIN, VMIN, VMIN, VMAX, VMAX, VMAX, 2'd2, 2'd3, 24'h000000, 24'h800000);
    send_pair(VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, 2'd3, 2'd0, 24'h000001, 24'hC00000);
    send_pair(VMAX, 0, 0, VMAX, 0, 0, 2'd3, 2'd3, 24'h400000, 24'h3FFFFF);
    send_pair(-1, -1, -1, 1, 1, 1, 2'd1, 2'd1, 24'h7FFFFF, 24'h7FFFFF);
    send_pair(123456, -654321, 0, -7, 99, 1 << 20, 2'd2, 2'd2, 24'hBFFFFF, 24'hBFFFFF);
    send_pair(VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, 2'd0, 2'd2, 24'h000000, 24'h000000);
    send_pair(VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, 2'd2, 2'd0, 24'hFFFFFF, 24'h400000);
    send_pair(1 << 30, -(1 << 30), 5, 0, 0, 0, 2'd1, 2'd3, 24'hC00000, 24'hFFFFFF);
    send_pair(0, 0, 0, VMIN, VMIN, VMIN, 2'd3, 2'd1, 24'h800000, 24'hC00000);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset masses
    send_directed();
    drain();
    // extremes, zero mass, out-of-range indexes
    write_mass(3'd0, 24'd1);
    write_mass(3'd1, 24'hFFFFFF);
    write_mass(3'd2, 24'd0);
    write_mass(3'd3, 24'd4096);
    write_mass(3'd4, 24'd7);
    write_mass(3'd7, 24'hFFFFFF);
    send_directed();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int m = 0; m < 4; m++) begin
        case (phase)
          1: write_mass(3'(m), 24'hFFFFFF);
          2: write_mass(3'(m), 24'd1);
          default: write_mass(3'(m), 24'($urandom_range(1, 16777215)));
        endcase
      end
      write_mass(3'($urandom_range(4, 7)), 24'($urandom));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random();
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        if (n % 40 == 39) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
